// File: sv/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types, field widths and the microcode program of the sorted-table
// search block.
// ----------------------------------------------------------------------------
package sbs_pkg;

   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_SIGNED = 2'd1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] STEP_IDLE = 2'd0;
   localparam logic [STEP_W-1:0] STEP_PROBE = 2'd1;
   localparam logic [STEP_W-1:0] STEP_COMPARE = 2'd2;
   localparam logic [STEP_W-1:0] STEP_REPORT = 2'd3;

   typedef enum logic [1:0] {
      COND_ALWAYS = 2'd0,
      COND_NOT_SEARCH = 2'd1,
      COND_COUNT_ZERO = 2'd2,
      COND_NOT_DONE = 2'd3
   } cond_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic probe;
      logic compare;
      logic report;
      cond_type cond;
      logic [STEP_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic count_zero;
      logic match_done;
   } stat_type;

   // on a true condition jump to target, otherwise fall through to the next step
   function automatic ctl_type ucode(input logic [STEP_W-1:0] step);
      ctl_type w;
      w = '{accept: 1'b0, load: 1'b0, probe: 1'b0, compare: 1'b0, report: 1'b0,
            cond: COND_ALWAYS, target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.load = 1'b1;
            w.cond = COND_NOT_SEARCH;
            w.target = STEP_IDLE;
         end
         STEP_PROBE: begin
            w.probe = 1'b1;
            w.cond = COND_COUNT_ZERO;
            w.target = STEP_REPORT;
         end
         STEP_COMPARE: begin
            w.compare = 1'b1;
            w.cond = COND_NOT_DONE;
            w.target = STEP_PROBE;
         end
         STEP_REPORT: begin
            w.report = 1'b1;
            w.cond = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: sv/sbs_ram.sv
// ----------------------------------------------------------------------------
// sbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sbs_seq.sv
// ----------------------------------------------------------------------------
// sbs_seq
// Step counter and microcode ROM; evaluates the jump condition of each word.
// ----------------------------------------------------------------------------
module sbs_seq
   import sbs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_op,
   input  stat_type stat,
   output ctl_type  ctl,
   output logic     busy
);

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   logic              taken;

   assign ctl = ucode(pc_ff);
   assign busy = (pc_ff != STEP_IDLE);

   always_comb begin
      case (ctl.cond)
         COND_ALWAYS:     taken = 1'b1;
         COND_NOT_SEARCH: taken = !(start && req_op == OP_SEARCH);
         COND_COUNT_ZERO: taken = stat.count_zero;
         COND_NOT_DONE:   taken = !stat.match_done;
         default:         taken = 1'b1;
      endcase
      pc_in = taken ? ctl.target : pc_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: sv/sbs_dp.sv
// ----------------------------------------------------------------------------
// sbs_dp
// Search datapath: window low/count, probe address, key compare and result.
// ----------------------------------------------------------------------------
module sbs_dp
   import sbs_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int KEY_WIDTH = 32
) (
   input  logic                     clock,
   input  ctl_type                  ctl,
   input  logic                     start,
   input  logic [COUNT_W-1:0]       entry_count,
   input  logic                     compare_signed,
   input  logic [KEY_WIDTH-1:0]     search_key,
   input  logic [KEY_WIDTH-1:0]     rd_data,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   output stat_type                 stat,
   output logic                     found,
   output logic [INDEX_W-1:0]       found_index
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [IW-1:0]        low_ff, low_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [IW-1:0]        probe_ff, probe_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        where_ff, where_in;

   logic [31:0]          count_sat;
   logic [CW-1:0]        half;
   logic [KEY_WIDTH-1:0] sign_flip;
   logic [KEY_WIDTH-1:0] entry_view;
   logic                 eq, lt;
   logic [31:0]          where_wide;

   // flipping the sign bit turns signed order into unsigned order
   assign sign_flip = {compare_signed, {(KEY_WIDTH-1){1'b0}}};
   assign entry_view = rd_data ^ sign_flip;
   assign eq = (key_ff == entry_view);
   assign lt = (key_ff < entry_view);

   assign count_sat = (32'(entry_count) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(entry_count);
   assign half = count_ff >> 1;
   assign probe_in = low_ff + half[IW-1:0];

   assign rd_en = ctl.probe;
   assign rd_addr = probe_in;

   assign stat.count_zero = (count_ff == '0);
   assign stat.match_done = eq || (count_ff == CW'(1));

   always_comb begin
      low_in = low_ff;
      count_in = count_ff;
      key_in = key_ff;
      hit_in = hit_ff;
      where_in = where_ff;
      if (ctl.load && start) begin
         low_in = '0;
         count_in = count_sat[CW-1:0];
         key_in = search_key ^ sign_flip;
         hit_in = 1'b0;
         where_in = '0;
      end else if (ctl.compare) begin
         if (eq) begin
            hit_in = 1'b1;
            where_in = probe_ff;
         end else if (count_ff != CW'(1)) begin
            if (lt) begin
               count_in = half;
            end else begin
               low_in = probe_ff;
               count_in = count_ff - half;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff <= low_in;
      count_ff <= count_in;
      key_ff <= key_in;
      hit_ff <= hit_in;
      where_ff <= where_in;
      if (ctl.probe) begin
         probe_ff <= probe_in;
      end
   end

   assign where_wide = 32'(where_ff);
   assign found = hit_ff;
   assign found_index = where_wide[INDEX_W-1:0];

endmodule

// File: sv/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted key table with a microcoded binary search over a registered-read RAM.
//
//   channel  ports                                   handshake
//   input    req_op req_entry_index req_entry_value  start high while busy low
//            req_search_key
//   result   rsp_found rsp_found_index               rsp_valid, one cycle
//   config   csr_index csr_write_data                csr_write_enable
//
// A write item leaves busy low. A search item with P probes keeps busy high
// through P probe and compare steps and a report step (only a probe and the
// report step for an empty window): each probe is a RAM read step and a compare
// step, P is at most ceil(log2(DEPTH))+1. The result shows in the last busy cycle.
// Reset clears the sequencer and the CSR registers; the table is undefined until
// written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top
   import sbs_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int KEY_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [KEY_WIDTH-1:0]  req_entry_value,
   input  logic [KEY_WIDTH-1:0]  req_search_key,
   output logic                  rsp_valid,
   output logic                  rsp_found,
   output logic [INDEX_W-1:0]    rsp_found_index,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IW = $clog2(DEPTH);

   logic [COUNT_W-1:0] entry_count_ff;
   logic               compare_signed_ff;
   ctl_type            ctl;
   stat_type           stat;
   logic               accept;
   logic               wr_en;
   logic [31:0]        wr_index_wide;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         compare_signed_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENTRY_COUNT:    entry_count_ff <= csr_write_data;
            CSR_COMPARE_SIGNED: compare_signed_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   assign accept = start && !busy;
   assign wr_index_wide = 32'(req_entry_index);
   assign wr_en = accept && req_op == OP_WRITE && wr_index_wide < 32'(DEPTH);

   sbs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .ctl    (ctl),
      .busy   (busy)
   );

   sbs_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_index_wide[IW-1:0]),
      .wr_data (req_entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sbs_dp #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock          (clock),
      .ctl            (ctl),
      .start          (start && ctl.accept && req_op == OP_SEARCH),
      .entry_count    (entry_count_ff),
      .compare_signed (compare_signed_ff),
      .search_key     (req_search_key),
      .rd_data        (rd_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .stat           (stat),
      .found          (rsp_found),
      .found_index    (rsp_found_index)
   );

   assign rsp_valid = ctl.report;

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a search");

   a_search_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_SEARCH) |=> busy) else $error("search item not taken");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_WRITE) |=> !busy) else $error("write item left block busy");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> rsp_found_index == '0) else $error("miss with index");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy) else $error("result repeated");

endmodule
